FILE: design/sse_pkg.sv
// Shared types and constants of the shell sort engine.
// No dependencies; every other source file but sse_ram imports this package.
package sse_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned EXT_W   = 64;

  typedef struct packed {
    logic in_rdy;
    logic pass_init;
    logic key_rd;
    logic key_ld;
    logic shift;
    logic place;
    logic advance;
    logic em_ld;
    logic clear;
  } sse_cmd_t;

  typedef struct packed {
    logic in_take;
    logic close;
    logic gap_zero;
    logic less;
    logic deep;
    logic em_last;
    logic out_free;
  } sse_sts_t;

endpackage

FILE: design/sse_in_if.sv
// Input channel of the shell sort engine: valid/ready plus value and last flag.
// Depends on sse_pkg.
interface sse_in_if import sse_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source(output valid, output value, output last, input ready);
  modport sink(input valid, input value, input last, output ready);
endinterface

FILE: design/sse_out_if.sv
// Output channel of the shell sort engine: valid/ready plus sorted value and final flag.
// Depends on sse_pkg.
interface sse_out_if import sse_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      final_res;

  modport source(output valid, output sorted_value, output final_res, input ready);
  modport sink(input valid, input sorted_value, input final_res, output ready);
endinterface

FILE: design/sse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sse_datapath.sv
// Datapath of the shell sort engine: element store, walkers, key and result register.
// Depends on sse_pkg, sse_in_if, sse_out_if and sse_ram.
module sse_datapath import sse_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sse_in_if.sink   in_i,
  sse_out_if.source out_o,
  input  sse_cmd_t cmd_i,
  output sse_sts_t sts_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         gap_q, gap_d;
  logic [AW-1:0]         outer_q, outer_d;
  logic [AW-1:0]         j_q, j_d;
  logic [DATA_WIDTH-1:0] key_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic                  out_final_q;
  logic                  out_valid_q, out_valid_d;

  logic                  in_take;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [EXT_W-1:0]      in_ext, out_ext;
  logic [AW-1:0]         j_m;
  logic [CW-1:0]         outer_nx;

  assign in_take  = in_i.valid && cmd_i.in_rdy;
  assign in_i.ready = cmd_i.in_rdy;
  assign in_ext   = {{(EXT_W - VALUE_W){in_i.value[VALUE_W-1]}}, in_i.value};
  assign j_m      = j_q - gap_q;
  assign outer_nx = CW'(outer_q) + CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = key_q;
    raddr = outer_q;
    if (in_take) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = in_ext[DATA_WIDTH-1:0];
    end else if (cmd_i.shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd_i.place) begin
      we    = 1'b1;
    end
    if (cmd_i.key_ld) begin
      raddr = j_m;
    end else if (cmd_i.shift) begin
      raddr = j_m - gap_q;
    end
  end

  sse_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d     = count_q;
    gap_d       = gap_q;
    outer_d     = outer_q;
    j_d         = j_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_take) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pass_init) begin
      gap_d   = AW'(count_q >> 1);
      outer_d = AW'(count_q >> 1);
    end
    if (cmd_i.key_rd) begin
      j_d = outer_q;
    end
    if (cmd_i.shift) begin
      j_d = j_m;
    end
    if (cmd_i.advance) begin
      if (outer_nx < count_q) begin
        outer_d = outer_q + AW'(1);
      end else begin
        gap_d   = gap_q >> 1;
        outer_d = gap_q >> 1;
      end
    end
    if (cmd_i.em_ld) begin
      outer_d     = outer_q + AW'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      outer_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      gap_q       <= '0;
      outer_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      gap_q       <= gap_d;
      outer_q     <= outer_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_ld) begin
      key_q <= rdata;
    end
    if (cmd_i.em_ld) begin
      out_data_q  <= rdata;
      out_final_q <= sts_o.em_last;
    end
  end

  assign out_ext            = EXT_W'($signed(out_data_q));
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_ext[VALUE_W-1:0];
  assign out_o.final_res    = out_final_q;

  assign sts_o.in_take  = in_take;
  assign sts_o.close    = in_i.last || ((count_q + CW'(1)) == CW'(MAX_ITEMS));
  assign sts_o.gap_zero = (gap_q == '0);
  assign sts_o.less     = $signed(key_q) < $signed(rdata);
  assign sts_o.deep     = (j_m >= gap_q);
  assign sts_o.em_last  = (outer_nx == count_q);
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  a_em_ld_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.em_ld |-> !out_valid_q)
    else $error("result loaded over a pending transaction");

  a_take_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (gap_q == '0))
    else $error("input transaction taken during sort");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("element count beyond store depth");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (gap_q != '0) && (j_q >= gap_q))
    else $error("shift outside store bounds");

endmodule

FILE: design/sse_ctrl.sv
// Controller of the shell sort engine: sequences load, gap passes and emission.
// Depends on sse_pkg.
module sse_ctrl import sse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sse_sts_t sts_i,
  output sse_cmd_t cmd_o
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_OUTER = 3'd2;
  localparam logic [2:0] ST_KEY   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_PLACE = 3'd5;
  localparam logic [2:0] ST_EMRD  = 3'd6;
  localparam logic [2:0] ST_EMLD  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.in_rdy = 1'b1;
        if (sts_i.in_take && sts_i.close) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.pass_init = 1'b1;
        state_d         = ST_OUTER;
      end
      ST_OUTER: begin
        if (sts_i.gap_zero) begin
          state_d = ST_EMRD;
        end else begin
          cmd_o.key_rd = 1'b1;
          state_d      = ST_KEY;
        end
      end
      ST_KEY: begin
        cmd_o.key_ld = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.less) begin
          cmd_o.shift = 1'b1;
          if (!sts_i.deep) begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.place   = 1'b1;
        cmd_o.advance = 1'b1;
        state_d       = ST_OUTER;
      end
      ST_EMRD: begin
        if (sts_i.out_free) begin
          state_d = ST_EMLD;
        end
      end
      ST_EMLD: begin
        cmd_o.em_ld = 1'b1;
        if (sts_i.em_last) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end else begin
          state_d = ST_EMRD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/shell_sort_engine.sv
// Loading: one value per cycle while in ST_LOAD. Sorting: ST_INIT sets up the gap; each
// insertion step reads the key in ST_OUTER and ST_KEY, compares and shifts in ST_CMP until
// its place is found and writes it in ST_PLACE. Emission uses the single store read port.
// Throughput: one set at a time, bounded by the compare-shift loop on the store.
// Reset: asynchronous active low; clears count, walkers and controller to loading.
// Top level of the shell sort engine; depends on sse_pkg, interfaces, sse_ctrl, sse_datapath.
module shell_sort_engine import sse_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sse_in_if.sink    in_i,
  sse_out_if.source out_o
);

  sse_cmd_t cmd;
  sse_sts_t sts;

  sse_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  sse_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

FILE: dv/tb_shell_sort_engine.sv
// Testbench for shell_sort_engine: drives signed values in sets over sse_in_if and checks the
// sorted output stream on sse_out_if against a Shell-sort predictor of its own.
// Depends on sse_pkg, sse_in_if, sse_out_if and shell_sort_engine.
module tb_shell_sort_engine import sse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_MAX    = 16;
  localparam int unsigned NUM_ITEMS  = 410;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned HOLD_AFTER = 60;

  typedef logic signed [VALUE_W-1:0] word_t;

  localparam word_t MIN_W = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam word_t MAX_W = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum int {VM_WIDE, VM_NARROW, VM_EXTREME, VM_RISING, VM_FALLING} value_mode_e;

  typedef struct {
    word_t       value;
    logic        last;
    int unsigned idle;
    bit          drain;
  } load_item_t;

  typedef struct packed {
    word_t value;
    logic  fin;
  } sorted_elem_t;

  logic clk_i;
  logic rst_ni;

  sse_in_if  in_if();
  sse_out_if out_if();

  shell_sort_engine u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  load_item_t   load_q[$];
  sorted_elem_t sorted_q[$];
  word_t        set_buf[SET_MAX];
  int unsigned  set_len = 0;
  int unsigned  sets_closed = 0;
  int unsigned  forced_closes = 0;
  int unsigned  err_cnt = 0;
  int unsigned  items_queued = 0;
  int unsigned  value_acc_cnt = 0;
  int unsigned  sorted_pred_cnt = 0;
  int unsigned  sorted_rx_cnt = 0;
  int unsigned  load_idle = 0;
  int unsigned  ready_stall = 0;
  int unsigned  calm_cnt = 0;
  int unsigned  idle_cycles = 0;
  bit           calm = 1'b0;
  bit           long_hold_done = 1'b0;
  bit           no_gaps = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic word_t pick_value(input value_mode_e mode, input word_t prev);
    case (mode)
      VM_NARROW:  return word_t'($urandom_range(0, 6)) - 3;
      VM_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       return MIN_W;
          1:       return MAX_W;
          2:       return MIN_W + 1;
          3:       return MAX_W - 1;
          4:       return '0;
          5:       return -1;
          default: return 1;
        endcase
      end
      VM_RISING:  return prev + word_t'($urandom_range(0, 1000));
      VM_FALLING: return prev - word_t'($urandom_range(0, 1000));
      default:    return word_t'($urandom);
    endcase
  endfunction

  task automatic queue_value(input word_t v, input logic lst, input bit drain = 1'b0);
    load_item_t  it;
    int unsigned r;
    r        = $urandom_range(0, 99);
    it.value = v;
    it.last  = lst;
    it.drain = drain;
    if (no_gaps || r < 60) it.idle = 0;
    else if (r < 92) it.idle = $urandom_range(1, 3);
    else it.idle = $urandom_range(8, 30);
    load_q.push_back(it);
    items_queued++;
  endtask

  task automatic queue_set(input int unsigned n, input bit close_last, input bit drain_first);
    value_mode_e mode;
    word_t       v;
    mode    = value_mode_e'($urandom_range(0, 4));
    no_gaps = ($urandom_range(0, 3) == 0);
    v       = word_t'($urandom);
    for (int unsigned k = 0; k < n; k++) begin
      v = pick_value(mode, v);
      queue_value(v, (k == n - 1) && close_last, drain_first && (k == 0));
    end
  endtask

  initial begin
    word_t       full_set[SET_MAX];
    int unsigned n;
    int unsigned r;
    full_set = '{MAX_W, MAX_W, 5, 4, 3, 2, 1, 0, 0, -1, -2, -3, -4, MIN_W + 1, MIN_W, MIN_W};
    rst_ni   = 1'b0;

    queue_value(MIN_W, 1'b1);
    queue_value(MAX_W, 1'b1);
    queue_value(MAX_W, 1'b0);
    queue_value(MIN_W, 1'b1);
    queue_value(-1, 1'b0);
    queue_value(0, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(1, 1'b1);
    foreach (full_set[k]) queue_value(full_set[k], 1'b0);

    queue_set(5, 1'b1, 1'b1);
    while (items_queued < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, SET_MAX - 1);
      else if (r < 88) n = SET_MAX;
      else n = $urandom_range(SET_MAX + 1, 2 * SET_MAX);
      queue_set(n, (n % SET_MAX != 0) || ($urandom_range(0, 1) == 1),
                $urandom_range(0, 19) == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (value_acc_cnt != items_queued) @(posedge clk_i);
    while (sorted_rx_cnt != sorted_pred_cnt) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (sorted_q.size() != 0) begin
      $display("%t %0d expected results never arrived", $time, sorted_q.size());
      err_cnt++;
    end
    $display("Sorted %0d sets from %0d values (%0d closed by a full store), %0d results checked.",
             sets_closed, value_acc_cnt, forced_closes, sorted_rx_cnt);
    $display("Run included single values, extremes, duplicates, a %0d-cycle output hold and drains.",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    load_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.value <= '0;
      in_if.last  <= 1'b0;
      load_idle   <= 0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold
    end else if (load_idle > 0) begin
      in_if.valid <= 1'b0;
      load_idle   <= load_idle - 1;
    end else if (load_q.size() != 0 &&
                 !(load_q[0].drain && (in_if.valid || sorted_rx_cnt != sorted_pred_cnt))) begin
      it = load_q.pop_front();
      in_if.valid <= 1'b1;
      in_if.value <= it.value;
      in_if.last  <= it.last;
      load_idle   <= it.idle;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    int unsigned  n;
    int unsigned  g;
    int unsigned  i;
    int unsigned  j;
    word_t        t;
    sorted_elem_t e;
    if (rst_ni && in_if.valid && in_if.ready) begin
      value_acc_cnt <= value_acc_cnt + 1;
      set_buf[set_len] = in_if.value;
      set_len++;
      if (in_if.last || set_len == SET_MAX) begin
        n = set_len;
        if (!in_if.last) forced_closes++;
        for (g = n / 2; g > 0; g = g / 2) begin
          for (i = g; i < n; i++) begin
            for (j = i; j >= g && set_buf[j] < set_buf[j - g]; j -= g) begin
              t              = set_buf[j];
              set_buf[j]     = set_buf[j - g];
              set_buf[j - g] = t;
            end
          end
        end
        for (i = 0; i < n; i++) begin
          e.value = set_buf[i];
          e.fin   = (i == n - 1);
          sorted_q.push_back(e);
        end
        sorted_pred_cnt <= sorted_pred_cnt + n;
        set_len = 0;
        sets_closed++;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      ready_stall  <= 0;
      calm_cnt     <= 0;
      calm         <= 1'b0;
    end else begin
      if (calm_cnt == 0) begin
        calm     <= ($urandom_range(0, 2) == 0);
        calm_cnt <= $urandom_range(20, 100);
      end else begin
        calm_cnt <= calm_cnt - 1;
      end
      r = $urandom_range(0, 99);
      if (ready_stall > 0) begin
        out_if.ready <= 1'b0;
        ready_stall  <= ready_stall - 1;
      end else if (!long_hold_done && sorted_rx_cnt >= HOLD_AFTER) begin
        out_if.ready   <= 1'b0;
        ready_stall    <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (calm || r < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        ready_stall  <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    sorted_elem_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sorted_q.size() == 0) begin
        $display("%t unexpected transaction: value %0d final %b", $time,
                 out_if.sorted_value, out_if.final_res);
        err_cnt++;
      end else begin
        e = sorted_q.pop_front();
        sorted_rx_cnt <= sorted_rx_cnt + 1;
        if (out_if.sorted_value !== e.value) begin
          $display("%t sorted_value mismatch: expected %0d actual %0d", $time,
                   e.value, out_if.sorted_value);
          err_cnt++;
        end
        if (out_if.final_res !== e.fin) begin
          $display("%t final_res mismatch: expected %b actual %b", $time,
                   e.fin, out_if.final_res);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%t timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: shell_sort_engine.f
design/sse_pkg.sv
design/sse_in_if.sv
design/sse_out_if.sv
design/sse_ram.sv
design/sse_datapath.sv
design/sse_ctrl.sv
design/shell_sort_engine.sv
dv/tb_shell_sort_engine.sv
